// File: rtl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// Debounced click classifier package
// Shared types, register indexes, event codes and reset values.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned TALLY_W   = 2;
  localparam int unsigned EVENT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 8'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd50;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd300;

  localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd3;

  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;

  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;
    logic              poll;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] click_event;
    logic [TIME_W-1:0]  last_click_ms;
  } result_t;

  typedef struct packed {
    logic               previous_raw;
    logic [TIME_W-1:0]  change_time;
    logic               stable_level;
    logic [TALLY_W-1:0] click_tally;
    logic [TIME_W-1:0]  click_time;
    logic               awaiting_second;
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] double_click_window;
  } cfg_t;

endpackage

// File: rtl/dcc_ifs.sv
// ----------------------------------------------------------------------------
// Debounced click classifier channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface dcc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      raw_level;
  logic [dcc_pkg::TIME_W-1:0] now_ms;
  logic                      poll;

  modport source (output valid, raw_level, now_ms, poll, input ready);
  modport sink (input valid, raw_level, now_ms, poll, output ready);
endinterface

interface dcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcc_pkg::EVENT_W-1:0] click_event;
  logic [dcc_pkg::TIME_W-1:0]  last_click_ms;

  modport source (output valid, click_event, last_click_ms, input ready);
  modport sink (input valid, click_event, last_click_ms, output ready);
endinterface

interface dcc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcc_pkg::CFG_IDX_W-1:0] index;
  logic [dcc_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/dcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Debounced click classifier configuration registers
// Holds the debounce time and the double-click window.
// ----------------------------------------------------------------------------
module dcc_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  dcc_cfg_if.sink        cfg_ch,
  output dcc_pkg::cfg_t  cfg
);

  dcc_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg         = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= dcc_pkg::DEBOUNCE_TIME_RST;
      cfg_r.double_click_window <= dcc_pkg::DOUBLE_WINDOW_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == dcc_pkg::REG_DEBOUNCE_TIME) begin
        cfg_r.debounce_time <= cfg_ch.data;
      end
      if (cfg_ch.index == dcc_pkg::REG_DOUBLE_WINDOW) begin
        cfg_r.double_click_window <= cfg_ch.data;
      end
    end
  end

endmodule

// File: rtl/dcc_update.sv
// ----------------------------------------------------------------------------
// Debounced click classifier update logic
// Computes the next state and the click event for one sample.
// ----------------------------------------------------------------------------
module dcc_update (
  input  dcc_pkg::state_t                 state,
  input  dcc_pkg::item_t                  item,
  input  dcc_pkg::cfg_t                   cfg,
  output dcc_pkg::state_t                 state_nxt,
  output logic [dcc_pkg::EVENT_W-1:0]     click_event
);

  logic [dcc_pkg::TIME_W-1:0]  change_time_a;
  logic [dcc_pkg::TIME_W-1:0]  deb_diff;
  logic [dcc_pkg::TIME_W-1:0]  win_diff;
  logic                        accept;
  logic                        click;
  logic [dcc_pkg::TALLY_W-1:0] tally_a;
  logic [dcc_pkg::TIME_W-1:0]  click_time_a;
  logic                        await_a;
  logic                        await_b;

  always_comb begin
    change_time_a = (item.raw_level != state.previous_raw) ? item.now_ms : state.change_time;
    deb_diff      = item.now_ms - change_time_a;
    accept        = (deb_diff > {16'd0, cfg.debounce_time}) &&
                    (item.raw_level != state.stable_level);
    click         = accept && !item.raw_level;

    tally_a = state.click_tally;
    if (click && state.click_tally != dcc_pkg::TALLY_MAX) begin
      tally_a = state.click_tally + 2'd1;
    end
    click_time_a = click ? item.now_ms : state.click_time;
    await_a      = (click && tally_a == 2'd1) ? 1'b1 : state.awaiting_second;

    win_diff = item.now_ms - click_time_a;
    await_b  = await_a && !(win_diff > {16'd0, cfg.double_click_window});

    state_nxt.previous_raw    = item.raw_level;
    state_nxt.change_time     = change_time_a;
    state_nxt.stable_level    = accept ? item.raw_level : state.stable_level;
    state_nxt.click_tally     = tally_a;
    state_nxt.click_time      = click_time_a;
    state_nxt.awaiting_second = await_b;
    click_event               = dcc_pkg::EV_NONE;

    if (item.poll && tally_a != 2'd0) begin
      priority if (tally_a >= 2'd2) begin
        state_nxt.click_tally     = 2'd0;
        state_nxt.awaiting_second = 1'b0;
        click_event               = dcc_pkg::EV_DOUBLE;
      end else if (!await_b) begin
        state_nxt.click_tally = 2'd0;
        click_event           = dcc_pkg::EV_SINGLE;
      end else begin
        click_event = dcc_pkg::EV_NONE;
      end
    end
  end

endmodule

// File: rtl/debounced_click_classifier_top.sv
// ----------------------------------------------------------------------------
// Debounced click classifier
// Debounces an active-low button and reports single and double clicks.
// ----------------------------------------------------------------------------
// Each transaction on in_ch carries one pin sample with its millisecond time
// stamp and a poll flag. Every sample yields exactly one transaction on
// out_ch with the click event and the time of the most recent click.
// The sample is captured in an input register; the state update then runs on
// it once the output side can advance and writes the result register, from
// which the result is offered on out_ch. While out_ch is not stalled, one
// sample is accepted per cycle; the single state update stage sets that
// rate.
// While out_ch is stalled the result register holds, one more sample waits in
// the input register, and in_ch.ready drops until the result is taken.
// cfg_ch writes the debounce time (index 0) and the double-click window
// (index 1); other indexes are ignored. Writes are always accepted and are
// expected only while no sample is in flight.
// Reset restores the default register values (50 and 300), clears all click
// state and empties both pipeline registers.
// ----------------------------------------------------------------------------
module debounced_click_classifier_top (
  input logic      clk,
  input logic      rst_n,
  dcc_in_if.sink   in_ch,
  dcc_out_if.source out_ch,
  dcc_cfg_if.sink  cfg_ch
);

  dcc_pkg::cfg_t    cfg;
  dcc_pkg::item_t   item_r;
  dcc_pkg::state_t  state_r;
  dcc_pkg::state_t  state_nxt;
  dcc_pkg::result_t result_r;
  logic [dcc_pkg::EVENT_W-1:0] event_nxt;
  logic in_valid_r;
  logic out_valid_r;
  logic advance;
  logic process;

  dcc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dcc_update u_update (
    .state       (state_r),
    .item        (item_r),
    .cfg         (cfg),
    .state_nxt   (state_nxt),
    .click_event (event_nxt)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign process     = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.click_event   = result_r.click_event;
  assign out_ch.last_click_ms = result_r.last_click_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (process) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.raw_level <= in_ch.raw_level;
      item_r.now_ms    <= in_ch.now_ms;
      item_r.poll      <= in_ch.poll;
    end
    if (process) begin
      result_r.click_event   <= event_nxt;
      result_r.last_click_ms <= state_nxt.click_time;
    end
  end

  a_no_wait_without_click: assert property (
    @(posedge clk) disable iff (!rst_n)
    state_r.click_tally == 2'd0 |-> !state_r.awaiting_second
  ) else $error("double-click wait open with no pending click");

  a_event_consumes: assert property (
    @(posedge clk) disable iff (!rst_n)
    process && event_nxt != dcc_pkg::EV_NONE |=> state_r.click_tally == 2'd0
  ) else $error("reported click was not consumed");

  a_event_code: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (result_r.click_event == dcc_pkg::EV_NONE ||
                     result_r.click_event == dcc_pkg::EV_SINGLE ||
                     result_r.click_event == dcc_pkg::EV_DOUBLE)
  ) else $error("invalid click event code");

  a_sample_kept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r)
  ) else $error("stalled sample lost");

endmodule

// File: sim/debounced_click_classifier_top_test.sv
// ----------------------------------------------------------------------------
// Debounced click classifier testbench
// Drives pin samples through the valid/ready input channel and checks every
// result against a cycle-free predictor of the debounce and click logic. A
// short table of hand-picked samples comes first, then randomized press and
// release sequences, noise and time jumps under several register settings,
// with random stalls on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module debounced_click_classifier_top_test;

  localparam logic [dcc_pkg::CFG_IDX_W-1:0] REG_NONE = '1;
  localparam int unsigned BACKLOG_CYCLES = 120;
  localparam int unsigned ROW_COUNT = 21;

  typedef struct packed {
    bit               typed;
    dcc_pkg::result_t gold;
  } sample_note_t;

  typedef struct packed {
    logic             raw_level;
    logic [31:0]      now_ms;
    logic             poll;
    bit               typed;
    dcc_pkg::result_t gold;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    '{1'b1, 32'd0,          1'b1, 1'b1, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'd51,         1'b0, 1'b1, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd100,        1'b1, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd150,        1'b1, 1'b1, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd151,        1'b1, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd451,        1'b1, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd452,        1'b1, 1'b1, '{dcc_pkg::EV_SINGLE, 32'd151}},
    '{1'b1, 32'd500,        1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'd600,        1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd610,        1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd700,        1'b1, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'd710,        1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'd800,        1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd810,        1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'd900,        1'b1, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'hFFFF_FFC0,  1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'h0000_0010,  1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'h0000_0020,  1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b0, 32'h0000_0060,  1'b1, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}},
    '{1'b1, 32'hFFFF_FFFF,  1'b1, 1'b1, '{dcc_pkg::EV_SINGLE, 32'h0000_0060}},
    '{1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, '{dcc_pkg::EV_NONE,   32'd0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dcc_in_if  in_ch ();
  dcc_out_if out_ch ();
  dcc_cfg_if cfg_ch ();

  debounced_click_classifier_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic                       pin_prev  = 1'b0;
  logic [dcc_pkg::TIME_W-1:0] edge_ms   = '0;
  logic                       level_now = 1'b0;
  logic [1:0]                 tally     = '0;
  logic [dcc_pkg::TIME_W-1:0] click_ms  = '0;
  logic                       wait_open = 1'b0;
  logic [dcc_pkg::CFG_W-1:0]  db_ms     = dcc_pkg::DEBOUNCE_TIME_RST;
  logic [dcc_pkg::CFG_W-1:0]  win_ms    = dcc_pkg::DOUBLE_WINDOW_RST;

  dcc_pkg::result_t expected_q [$];
  sample_note_t     typed_q [$];

  int unsigned sent_count = 0;
  int unsigned received_count = 0;
  int unsigned mismatches = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  bit          quiet = 1'b0;
  bit          calm = 1'b0;

  logic [dcc_pkg::TIME_W-1:0] clock_ms = '0;
  int unsigned                phase_db = dcc_pkg::DEBOUNCE_TIME_RST;
  int unsigned                phase_win = dcc_pkg::DOUBLE_WINDOW_RST;

  function automatic dcc_pkg::result_t classify_sample(dcc_pkg::item_t s);
    dcc_pkg::result_t           r;
    logic [dcc_pkg::TIME_W-1:0] since_edge;
    logic [dcc_pkg::TIME_W-1:0] since_click;
    r.click_event = dcc_pkg::EV_NONE;
    if (s.raw_level != pin_prev) begin
      edge_ms  = s.now_ms;
      pin_prev = s.raw_level;
    end
    since_edge = s.now_ms - edge_ms;
    if (since_edge > {16'd0, db_ms} && s.raw_level != level_now) begin
      level_now = s.raw_level;
      if (!s.raw_level) begin
        if (tally != dcc_pkg::TALLY_MAX) tally = tally + 2'd1;
        click_ms = s.now_ms;
        if (tally == 2'd1) wait_open = 1'b1;
      end
    end
    since_click = s.now_ms - click_ms;
    if (wait_open && since_click > {16'd0, win_ms}) wait_open = 1'b0;
    if (s.poll && tally != 2'd0) begin
      if (tally >= 2'd2) begin
        tally = 2'd0;
        wait_open = 1'b0;
        r.click_event = dcc_pkg::EV_DOUBLE;
      end else if (!wait_open) begin
        tally = 2'd0;
        r.click_event = dcc_pkg::EV_SINGLE;
      end
    end
    r.last_click_ms = click_ms;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    dcc_pkg::item_t   sample;
    dcc_pkg::result_t predicted;
    dcc_pkg::result_t actual;
    dcc_pkg::result_t wanted;
    sample_note_t     note;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == dcc_pkg::REG_DEBOUNCE_TIME) db_ms = cfg_ch.data;
        else if (cfg_ch.index == dcc_pkg::REG_DOUBLE_WINDOW) win_ms = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        sample.raw_level = in_ch.raw_level;
        sample.now_ms    = in_ch.now_ms;
        sample.poll      = in_ch.poll;
        predicted = classify_sample(sample);
        if (typed_q.size() != 0) begin
          note = typed_q.pop_front();
          if (note.typed) predicted = note.gold;
        end
        expected_q.push_back(predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        received_count++;
        actual.click_event   = out_ch.click_event;
        actual.last_click_ms = out_ch.last_click_ms;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result click_event %0d last_click_ms %h",
                     $time, actual.click_event, actual.last_click_ms);
        end else begin
          wanted = expected_q.pop_front();
          if (actual.click_event !== wanted.click_event ||
              actual.last_click_ms !== wanted.last_click_ms) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: click_event exp %0d got %0d, last_click_ms exp %h got %h",
                       $time, wanted.click_event, actual.click_event,
                       wanted.last_click_ms, actual.last_click_ms);
          end
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned calm_left;
    calm_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done++;
        out_ch.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && calm_left == 0 && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(20, 100);
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left != 0) calm_left--;
      end
    end
  end

  function automatic logic poll_coin();
    return $urandom_range(0, 5) == 0;
  endfunction

  task automatic drive_sample(logic lvl, logic [dcc_pkg::TIME_W-1:0] t, logic p, bit typed,
                              dcc_pkg::result_t gold);
    sample_note_t note;
    if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    note.typed = typed;
    note.gold  = gold;
    typed_q.push_back(note);
    in_ch.valid     <= 1'b1;
    in_ch.raw_level <= lvl;
    in_ch.now_ms    <= t;
    in_ch.poll      <= p;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic hold_level(logic lvl, int unsigned span);
    int unsigned                steps;
    logic [dcc_pkg::TIME_W-1:0] t0;
    steps = $urandom_range(1, 4);
    t0 = clock_ms;
    drive_sample(lvl, t0, poll_coin(), 1'b0, '0);
    for (int i = 1; i < steps; i++)
      drive_sample(lvl, t0 + span * i / steps, poll_coin(), 1'b0, '0);
    clock_ms = t0 + span;
    drive_sample(lvl, clock_ms, poll_coin(), 1'b0, '0);
  endtask

  task automatic click_burst();
    int unsigned clicks;
    int unsigned gap;
    clicks = $urandom_range(1, 4);
    for (int c = 0; c < clicks; c++) begin
      if ($urandom_range(0, 3) == 0) begin
        hold_level(1'b0, $urandom_range(0, phase_db));
        hold_level(1'b1, $urandom_range(0, phase_db));
      end
      hold_level(1'b0, phase_db + $urandom_range(1, 40));
      if ($urandom_range(0, 1) != 0) gap = phase_db + $urandom_range(1, phase_win / 2 + 1);
      else gap = phase_db + phase_win + $urandom_range(1, 200);
      hold_level(1'b1, gap);
    end
    repeat ($urandom_range(1, 3)) begin
      clock_ms = clock_ms + $urandom_range(0, phase_win + 60);
      drive_sample(1'b1, clock_ms, 1'b1, 1'b0, '0);
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      calm = $urandom_range(0, 3) == 0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        click_burst();
      end else if (pick < 8) begin
        repeat ($urandom_range(2, 10)) begin
          clock_ms = clock_ms + $urandom_range(0, phase_db + 2);
          drive_sample(1'($urandom_range(0, 1)), clock_ms, poll_coin(), 1'b0, '0);
        end
      end else begin
        if (pick == 8) clock_ms = $urandom;
        else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
        drive_sample(1'($urandom_range(0, 1)), clock_ms, poll_coin(), 1'b0, '0);
      end
    end
  endtask

  task automatic write_register(logic [dcc_pkg::CFG_IDX_W-1:0] idx,
                                logic [dcc_pkg::CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(int unsigned db, int unsigned win);
    in_ch.valid <= 1'b0;
    while (received_count != sent_count) @(posedge clk);
    write_register(dcc_pkg::REG_DEBOUNCE_TIME, dcc_pkg::CFG_W'(db));
    write_register(dcc_pkg::REG_DOUBLE_WINDOW, dcc_pkg::CFG_W'(win));
    phase_db  = db;
    phase_win = win;
  endtask

  initial begin : stimulus
    in_ch.valid     <= 1'b0;
    in_ch.raw_level <= 1'b1;
    in_ch.now_ms    <= '0;
    in_ch.poll      <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    rst_n           <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROW_COUNT; r++)
      drive_sample(DIRECTED_ROWS[r].raw_level, DIRECTED_ROWS[r].now_ms,
                   DIRECTED_ROWS[r].poll, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].gold);
    clock_ms = 32'hFFFF_FFFF;

    reconfigure(0, 0);
    write_register(REG_NONE, dcc_pkg::CFG_W'($urandom));
    run_random(160);

    reconfigure(16'hFFFF, 16'hFFFF);
    hold_asked++;
    run_random(160);

    reconfigure($urandom_range(1, 200), $urandom_range(0, 1000));
    write_register(dcc_pkg::CFG_IDX_W'($urandom_range(dcc_pkg::REG_DOUBLE_WINDOW + 1,
                                                      REG_NONE)),
                   dcc_pkg::CFG_W'($urandom));
    run_random(160);

    reconfigure(30, 250);
    run_random(160);

    reconfigure(dcc_pkg::DEBOUNCE_TIME_RST, dcc_pkg::DOUBLE_WINDOW_RST);
    quiet = 1'b1;
    calm  = 1'b1;
    run_random(160);

    in_ch.valid <= 1'b0;
    for (int w = 0; w < 4000 && received_count != sent_count; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
